// ----- hw/rtl/i2c_master_byte_engine_assert.svh -----
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_ASSERT_SVH

// Check a property outside reset.
`define I2CM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("i2cm assertion failed");

// Check a property at every clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("i2cm assertion failed");

`endif

// ----- hw/rtl/i2cm_pkg.sv -----
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 1'b1;

  localparam logic [7:0] PHASE_TICKS_RESET = 8'd2;
  localparam logic [7:0] ACK_LIMIT_RESET   = 8'd250;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_WAIT  = 3'd5;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_READ,
    KIND_WAIT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] wr_byte;
    logic       give_ack;
    logic       sda_sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_port_t;

endpackage

// ----- hw/rtl/i2cm_front.sv -----
// Front end: accepts input items, classifies the op code and hands them to the queue.
module i2cm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        op,
  input  logic [7:0]        wr_byte,
  input  logic              give_ack,
  input  logic              sda_sample,
  input  logic              q_full,
  output i2cm_pkg::q_port_t push
);
  import i2cm_pkg::*;

  logic  held;
  item_t item;
  kind_t kind_next;
  logic  take;
  logic  send;

  always_comb begin
    unique case (op)
      OP_START: kind_next = KIND_START;
      OP_STOP:  kind_next = KIND_STOP;
      OP_WRITE: kind_next = KIND_WRITE;
      OP_READ:  kind_next = KIND_READ;
      OP_WAIT:  kind_next = KIND_WAIT;
      default:  kind_next = KIND_TICK;
    endcase
  end

  assign send     = held && !q_full;
  assign in_stall = held && q_full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (send) begin
      held <= 1'b0;
    end
    if (take) begin
      item.kind       <= kind_next;
      item.wr_byte    <= wr_byte;
      item.give_ack   <= give_ack;
      item.sda_sample <= sda_sample;
    end
  end

  assign push.valid = send;
  assign push.item  = item;

endmodule

// ----- hw/rtl/i2cm_queue.sv -----
// Short FIFO of classified items between the front end and the bus engine.
module i2cm_queue #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  i2cm_pkg::q_port_t push,
  output logic              full,
  output i2cm_pkg::q_port_t head,
  input  logic              pop
);
  import i2cm_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            entries [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full       = (count == CntW'(QueueDepth));
  assign do_push    = push.valid && !full;
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({do_push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
    if (do_push) begin
      entries[wr_ptr] <= push.item;
    end
  end

  `include "i2c_master_byte_engine_assert.svh"

  `I2CM_ASSERT_ALWAYS(a_count_bound, clk, rst || (count <= CntW'(QueueDepth)))
  `I2CM_ASSERT(a_no_pop_empty, clk, rst, pop |-> count != '0)

endmodule

// ----- hw/rtl/i2cm_back.sv -----
// Bus engine: steps SCL/SDA phases one item per unstalled cycle, registers results.
module i2cm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  i2cm_pkg::q_port_t                   head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                scl_level,
  output logic                                sda_level,
  output logic                                busy_res,
  output logic                                done_res,
  output logic [7:0]                          rd_byte,
  output logic                                ack_failed
);
  import i2cm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_L,
    PH_WR_H, PH_RD_L, PH_RD_H, PH_AK_L, PH_AK_H, PH_WAIT
  } phase_t;

  logic [7:0] phase_ticks;
  logic [7:0] ack_limit;

  phase_t     phase, phase_next;
  logic       is_read, is_read_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] tick_count, tick_count_next;
  logic [7:0] poll_count, poll_count_next;
  logic       ack_choice, ack_choice_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;
  logic       fail_flag, fail_flag_next;
  logic       done;
  logic       elapsed;
  logic [8:0] limit;
  item_t      it;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid || !out_stall);

  assign limit   = {1'b0, (phase_ticks == 8'd0) ? 8'd1 : phase_ticks};
  assign elapsed = ({1'b0, tick_count} + 9'd1) >= limit;

  always_comb begin
    phase_next      = phase;
    is_read_next    = is_read;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    tick_count_next = tick_count;
    poll_count_next = poll_count;
    ack_choice_next = ack_choice;
    scl_drive_next  = scl_drive;
    sda_drive_next  = sda_drive;
    fail_flag_next  = fail_flag;
    done            = 1'b0;
    if (phase == PH_IDLE && it.kind != KIND_TICK) begin
      is_read_next    = (it.kind == KIND_READ);
      fail_flag_next  = 1'b0;
      tick_count_next = 8'd0;
      bit_count_next  = 4'd0;
      unique case (it.kind)
        KIND_START: begin
          sda_drive_next = 1'b1;
          scl_drive_next = 1'b1;
          phase_next     = PH_ST_A;
        end
        KIND_STOP: begin
          sda_drive_next = 1'b0;
          scl_drive_next = 1'b0;
          phase_next     = PH_SP_A;
        end
        KIND_WRITE: begin
          scl_drive_next  = 1'b0;
          shift_byte_next = it.wr_byte;
          phase_next      = PH_WR_L;
        end
        KIND_READ: begin
          sda_drive_next  = 1'b1;
          scl_drive_next  = 1'b0;
          shift_byte_next = 8'd0;
          ack_choice_next = it.give_ack;
          phase_next      = PH_RD_L;
        end
        default: begin
          sda_drive_next  = 1'b1;
          scl_drive_next  = 1'b1;
          poll_count_next = 8'd0;
          phase_next      = PH_WAIT;
        end
      endcase
    end else if (phase == PH_WAIT) begin
      if (!it.sda_sample) begin
        scl_drive_next = 1'b0;
        phase_next     = PH_IDLE;
        done           = 1'b1;
      end else if (({1'b0, poll_count} + 9'd1) > {1'b0, ack_limit}) begin
        fail_flag_next  = 1'b1;
        sda_drive_next  = 1'b0;
        scl_drive_next  = 1'b0;
        tick_count_next = 8'd0;
        phase_next      = PH_SP_A;
      end else begin
        poll_count_next = poll_count + 8'd1;
      end
    end else if (phase != PH_IDLE) begin
      if (!elapsed) begin
        tick_count_next = tick_count + 8'd1;
      end else begin
        tick_count_next = 8'd0;
        unique case (phase)
          PH_ST_A: begin
            sda_drive_next = 1'b0;
            phase_next     = PH_ST_B;
          end
          PH_ST_B: begin
            scl_drive_next = 1'b0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end
          PH_SP_A: begin
            scl_drive_next = 1'b1;
            sda_drive_next = 1'b1;
            phase_next     = PH_SP_B;
          end
          PH_SP_B: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          PH_WR_L: begin
            sda_drive_next  = shift_byte[7];
            shift_byte_next = {shift_byte[6:0], 1'b0};
            scl_drive_next  = 1'b1;
            phase_next      = PH_WR_H;
          end
          PH_WR_H: begin
            scl_drive_next = 1'b0;
            bit_count_next = bit_count + 4'd1;
            if (bit_count >= 4'd7) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next = PH_WR_L;
            end
          end
          PH_RD_L: begin
            scl_drive_next = 1'b1;
            phase_next     = PH_RD_H;
          end
          PH_RD_H: begin
            shift_byte_next = {shift_byte[6:0], it.sda_sample};
            scl_drive_next  = 1'b0;
            bit_count_next  = bit_count + 4'd1;
            if (bit_count >= 4'd7) begin
              sda_drive_next = !ack_choice;
              phase_next     = PH_AK_L;
            end else begin
              phase_next = PH_RD_L;
            end
          end
          PH_AK_L: begin
            scl_drive_next = 1'b1;
            phase_next     = PH_AK_H;
          end
          PH_AK_H: begin
            scl_drive_next = 1'b0;
            phase_next     = PH_IDLE;
            done           = 1'b1;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
      ack_limit   <= ACK_LIMIT_RESET;
      phase       <= PH_IDLE;
      is_read     <= 1'b0;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      tick_count  <= 8'd0;
      poll_count  <= 8'd0;
      ack_choice  <= 1'b0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
      fail_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_PHASE_TICKS) begin
        phase_ticks <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_ACK_LIMIT) begin
        ack_limit <= cfg_data;
      end
      if (pop) begin
        phase      <= phase_next;
        is_read    <= is_read_next;
        bit_count  <= bit_count_next;
        shift_byte <= shift_byte_next;
        tick_count <= tick_count_next;
        poll_count <= poll_count_next;
        ack_choice <= ack_choice_next;
        scl_drive  <= scl_drive_next;
        sda_drive  <= sda_drive_next;
        fail_flag  <= fail_flag_next;
        out_valid  <= 1'b1;
        scl_level  <= scl_drive_next;
        sda_level  <= sda_drive_next;
        busy_res   <= (phase_next != PH_IDLE);
        done_res   <= done;
        rd_byte    <= is_read_next ? shift_byte_next : 8'd0;
        ack_failed <= fail_flag_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `include "i2c_master_byte_engine_assert.svh"

  `I2CM_ASSERT(a_idle_tick_clear, clk, rst, (phase == PH_IDLE) |-> (tick_count == 8'd0))
  `I2CM_ASSERT(a_bit_count_bound, clk, rst, bit_count <= 4'd8)
  `I2CM_ASSERT(a_pop_loads_result, clk, rst, pop |=> out_valid)

endmodule

// ----- hw/rtl/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: front end, item queue and bus engine.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   op, wr_byte, give_ack, sda_sample
//   out      output     out_valid / out_stall scl_level, sda_level, busy_res,
//                                             done_res, rd_byte, ack_failed
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One item a cycle sustained while out_stall is low; an accepted item passes through the
// front register, the queue entry and the result register before its result is presented.
// Synchronous reset clears control state and loads phase_ticks 2, ack_limit 250.
// A stalled result holds while the queue and the front register absorb up to
// QueueDepth + 1 more items.
module i2c_master_byte_engine #(
  parameter int unsigned QueueDepth = i2cm_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      op,
  input  logic [7:0]                      wr_byte,
  input  logic                            give_ack,
  input  logic                            sda_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            scl_level,
  output logic                            sda_level,
  output logic                            busy_res,
  output logic                            done_res,
  output logic [7:0]                      rd_byte,
  output logic                            ack_failed,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import i2cm_pkg::*;

  q_port_t push;
  q_port_t head;
  logic    q_full;
  logic    pop;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .wr_byte    (wr_byte),
    .give_ack   (give_ack),
    .sda_sample (sda_sample),
    .q_full     (q_full),
    .push       (push)
  );

  i2cm_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .rd_byte    (rd_byte),
    .ack_failed (ack_failed)
  );

endmodule
